// ===== src/itar_pkg.sv =====
// Package for the integer to ASCII radix converter.
// Holds the fixed field widths, the ASCII and radix constants and the digit encoder.
// No dependencies.
`timescale 1ns / 1ps

package itar_pkg;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;

    localparam logic [DIGIT_W-1:0] LAST_NUMERAL  = 6'd9;
    localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_Z     = 7'h5A;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;

    // Digit values 0..9 map to numerals, 10..35 to uppercase letters.
    function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] letter;
        letter = d - LETTER_OFFSET;
        if (d > LAST_NUMERAL)
            return CHAR_W'(letter) + ASCII_A;
        else
            return CHAR_W'(d) + ASCII_ZERO;
    endfunction

endpackage

// ===== src/itar_if.sv =====
// Channel interfaces for the integer to ASCII radix converter.
// itar_value_if carries the integer in, itar_char_if the characters out; uses itar_pkg.
`timescale 1ns / 1ps

interface itar_value_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itar_char_if
    import itar_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              bad_radix;

    modport source (output valid, output character, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input character, input last, input bad_radix,
                    output ready);
endinterface

// ===== src/itar_divider.sv =====
// Restoring divider: one quotient bit per cycle, divisor up to 6 bits.
// Used by the converter top level to peel digits off the magnitude; uses itar_pkg.
`timescale 1ns / 1ps

module itar_divider
    import itar_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [RADIX_W-1:0]     divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [DIGIT_W-1:0]     remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     div_reg, div_next;

    logic [DIGIT_W:0]       trial;
    logic [DIGIT_W:0]       diff;
    logic                   fits;

    always_comb
    begin
        trial = {rem_reg, quot_reg[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = trial >= {1'b0, div_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so both arms fit in six bits.
            rem_next  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            quot_next = {quot_reg[VALUE_WIDTH-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/integer_to_ascii_radix_top.sv =====
// Top level of the integer to ASCII radix converter.
// Depends on itar_pkg, itar_if.sv (channel interfaces) and itar_divider.
//
//   Channel   Dir  Beat payload                          Handshake
//   -------   ---  ------------------------------------  ---------------------
//   operand   in   value (VALUE_WIDTH bits, signed)      valid / ready
//   text      out  character (7), last (1), bad_radix    valid / ready
//   radix     cfg  radix_wdata (6 bits)                  radix_we, no back-pressure
//
// After acceptance each digit takes a divider start, a one-bit-per-cycle divider
// pass and a done, and is stored; then a minus sign is sent when there is one, and
// each digit is sent with a digit store read and an emit, most significant first.
// Text stalls hold the sequencer in its sign and emit states.
// A bad radix presents its single beat from its own state once the text slot is free.
// Reset clears the sequencer, counters and output valid and loads radix 10; the
// digit store needs no clearing, as every entry read was written in the same number.
// The operand channel is ready only when the sequencer is idle; a stalled text beat
// holds it in a sign, emit or bad state, and no character is lost or repeated.
`timescale 1ns / 1ps

module integer_to_ascii_radix_top
    import itar_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    itar_value_if.sink         operand,
    itar_char_if.source        text,
    input  logic               radix_we,
    input  logic [RADIX_W-1:0] radix_wdata
);

    // Count holds 0..VALUE_WIDTH digits; the store index only needs the depth.
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAD,
        S_DIV,
        S_WAIT,
        S_SIGN,
        S_READ,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   bad_reg, bad_next;

    // Digit store: least significant digit at index 0.
    logic [DIGIT_W-1:0]     digit_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0]     rd_data_reg;
    logic                   wr_en;
    logic                   rd_en;
    logic [CNT_W-1:0]       count_dec;

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [DIGIT_W-1:0]     div_rem;

    logic                   radix_ok;
    logic                   in_neg;
    logic                   slot_free;
    logic                   accept;

    assign count_dec = count_reg - 1'b1;
    assign slot_free = !out_valid_reg || text.ready;
    assign accept    = operand.valid && operand.ready;

    always_comb
    begin
        radix_ok = radix_reg inside {[RADIX_MIN:RADIX_MAX]};
        in_neg   = operand.value[VALUE_WIDTH-1] && (radix_reg == RADIX_DECIMAL);
    end

    itar_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !text.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = in_neg;
                    mag_next   = in_neg ? (~operand.value[VALUE_WIDTH-1:0] + 1'b1)
                                        : operand.value[VALUE_WIDTH-1:0];
                    count_next = '0;
                    state_next = radix_ok ? S_DIV : S_BAD;
                end
            end
            S_BAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_NONE;
                    last_next      = 1'b1;
                    bad_next       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (count_reg < CNT_W'(VALUE_WIDTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    mag_next = div_quot;
                    if (div_quot != '0)
                        state_next = S_DIV;
                    else
                        state_next = neg_reg ? S_SIGN : S_READ;
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_MINUS;
                    last_next      = 1'b0;
                    bad_next       = 1'b0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ascii_of_digit(rd_data_reg);
                    last_next      = (count_reg == CNT_W'(1));
                    bad_next       = 1'b0;
                    count_next     = count_dec;
                    state_next     = (count_reg == CNT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radix_reg     <= RADIX_RESET;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (radix_we)
                radix_reg <= radix_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            digit_mem[count_reg[IDX_W-1:0]] <= div_rem;
        if (rd_en)
            rd_data_reg <= digit_mem[count_dec[IDX_W-1:0]];
    end

    assign operand.ready  = (state_reg == S_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;
    assign text.bad_radix = bad_reg;

endmodule

// ===== src/itar_checker.sv =====
// Port-level checks for the integer to ASCII radix converter, bound to its top level.
// Depends on itar_pkg and integer_to_ascii_radix_top.
`timescale 1ns / 1ps

module itar_checker
    import itar_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              op_valid,
    input logic              op_ready,
    input logic              txt_valid,
    input logic              txt_ready,
    input logic [CHAR_W-1:0] txt_char,
    input logic              txt_last,
    input logic              txt_bad
);

    // A stalled text beat keeps its payload.
    a_text_hold: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && !txt_ready |=> txt_valid && $stable(txt_char)
            && $stable(txt_last) && $stable(txt_bad))
        else $error("text beat changed while stalled");

    // A bad radix beat is the only beat of its number and carries no character.
    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && txt_bad |-> txt_last && (txt_char == CHAR_NONE))
        else $error("bad radix beat malformed");

    // Ordinary beats are numerals, uppercase letters or a minus sign.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && !txt_bad |->
            ((txt_char >= ASCII_ZERO) && (txt_char <= ASCII_NINE))
            || ((txt_char >= ASCII_A) && (txt_char <= ASCII_Z))
            || (txt_char == ASCII_MINUS))
        else $error("unexpected character");

    // The sign never ends a number.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && (txt_char == ASCII_MINUS) |-> !txt_last)
        else $error("minus sign marked last");

    // Once a number is taken the converter is busy with it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_ready |=> !op_ready)
        else $error("operand accepted back to back");

endmodule

bind integer_to_ascii_radix_top itar_checker u_itar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (operand.valid),
    .op_ready  (operand.ready),
    .txt_valid (text.valid),
    .txt_ready (text.ready),
    .txt_char  (text.character),
    .txt_last  (text.last),
    .txt_bad   (text.bad_radix)
);

// ===== bench/tb_integer_to_ascii_radix_top.sv =====
// Self-checking testbench for integer_to_ascii_radix_top.
// Drives signed integers in, checks the ASCII text beats against its own predictor.
// Depends on itar_pkg, itar_if.sv and the block's top level.
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix_top;
    import itar_pkg::*;

    localparam int VALUE_W      = 32;
    localparam int SETTLE_CYCLES = 8;     // margin for the block to drop back to idle
    localparam int DRAIN_CYCLES  = 60;
    localparam int HOLD_CYCLES   = 3000;  // long receiver hold-off
    localparam int REPORT_CAP    = 60;

    // One text beat as the block presents it.
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_radix;
    } text_beat_t;

    // Scoreboard: spells each accepted number in the current radix and holds the
    // characters still owed by the block, oldest first.
    class radix_text_scoreboard;
        logic [RADIX_W-1:0] radix;
        text_beat_t         owed_chars[$];
        int unsigned        bad_chars;
        int unsigned        reported;

        function new();
            radix     = RADIX_RESET;
            bad_chars = 0;
            reported  = 0;
        endfunction

        function void set_radix(input logic [RADIX_W-1:0] r);
            radix = r;
        endfunction

        function void spell_number(input logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] magnitude;
            logic [VALUE_W-1:0] base;
            logic [DIGIT_W-1:0] digits [VALUE_W];
            logic [DIGIT_W-1:0] d;
            logic [CHAR_W-1:0]  ch;
            logic               minus;
            int                 n;
            int                 i;
            if (radix < RADIX_MIN || radix > RADIX_MAX) begin
                owed_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
                return;
            end
            base      = VALUE_W'(radix);
            minus     = v[VALUE_W-1] && (radix == RADIX_DECIMAL);
            magnitude = minus ? (~v + 1'b1) : v;
            n = 0;
            // Digits come out least significant first.
            do
            begin
                digits[n] = DIGIT_W'(magnitude % base);
                n++;
                magnitude = magnitude / base;
            end
            while (magnitude != 0);
            if (minus)
                owed_chars.push_back('{ASCII_MINUS, 1'b0, 1'b0});
            for (i = n - 1; i >= 0; i--)
            begin
                d  = digits[i];
                ch = (d > LAST_NUMERAL) ? CHAR_W'(d - LETTER_OFFSET) + ASCII_A
                                        : CHAR_W'(d) + ASCII_ZERO;
                owed_chars.push_back('{ch, (i == 0), 1'b0});
            end
        endfunction

        function void check_char(input text_beat_t got);
            text_beat_t want;
            if (owed_chars.size() == 0) begin
                bad_chars++;
                if (reported < REPORT_CAP) begin
                    reported++;
                    $display("%0t: text beat with nothing owed: char %h last %b bad_radix %b",
                             $time, got.character, got.last, got.bad_radix);
                end
                return;
            end
            want = owed_chars.pop_front();
            if (got.character !== want.character || got.last !== want.last
                || got.bad_radix !== want.bad_radix) begin
                bad_chars++;
                if (reported < REPORT_CAP) begin
                    reported++;
                    $display("%0t: text beat mismatch: expected char %h last %b bad_radix %b, actual char %h last %b bad_radix %b",
                             $time, want.character, want.last, want.bad_radix,
                             got.character, got.last, got.bad_radix);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               radix_we;
    logic [RADIX_W-1:0] radix_wdata;

    itar_value_if #(.WIDTH(VALUE_W)) operand_if ();
    itar_char_if                     text_if ();

    radix_text_scoreboard sb = new();

    // Phase controls shared between the sender and the receiver. A quiet phase has
    // no idling on either side; a hold request makes the receiver stall for a long
    // stretch while the sender keeps offering numbers.
    bit quiet_phase;
    bit hold_request;

    integer_to_ascii_radix_top #(
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .operand     (operand_if),
        .text        (text_if),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offers one number after a random gap and waits for its beat to be taken.
    // The caller always stands at a rising edge, so valid gets at most one update
    // per time step: it is only lowered when a gap is actually inserted.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        int roll;
        roll = $urandom_range(99);
        if (quiet_phase || roll < 60)
            gap = 0;
        else if (roll < 94)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(20, 80);
        if (gap > 0)
        begin
            operand_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_if.valid <= 1'b1;
        operand_if.value <= v;
        // Values seen just after the edge are those the block sampled at it.
        do
            @(posedge clk);
        while (!operand_if.ready);
        sb.spell_number(v);
    endtask

    // Changes the radix only once the block has sent every owed character and
    // has then been given SETTLE_CYCLES to settle back to idle.
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        operand_if.valid <= 1'b0;
        while (sb.owed_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        radix_we    <= 1'b1;
        radix_wdata <= r;
        @(posedge clk);
        radix_we <= 1'b0;
        sb.set_radix(r);
    endtask

    // Receiver: checks every accepted text beat and decides ready for the next
    // cycle. Most stalls are short, a few long, and a hold request overrides both.
    initial
    begin
        int stall;
        int roll;
        stall = 0;
        text_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (text_if.valid === 1'b1 && text_if.ready === 1'b1)
                sb.check_char(text_beat_t'{text_if.character, text_if.last,
                                           text_if.bad_radix});
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                text_if.ready <= 1'b0;
                stall--;
            end
            else if (quiet_phase)
                text_if.ready <= 1'b1;
            else
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    text_if.ready <= 1'b1;
                else
                begin
                    text_if.ready <= 1'b0;
                    stall = (roll < 96) ? $urandom_range(0, 3) : $urandom_range(20, 80);
                end
            end
        end
    end

    // Stimulus: a directed pass over the extremes and special cases, then random
    // phases, each with its own radix, mixing legal and illegal settings.
    initial
    begin
        logic [RADIX_W-1:0] phase_radix [12];
        logic [RADIX_W-1:0] r;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        logic [VALUE_W-1:0] base;
        bit                 bad;
        int                 count;
        int                 k;
        int                 ph;
        int                 n;

        rst_n            <= 1'b0;
        radix_we         <= 1'b0;
        radix_wdata      <= '0;
        operand_if.valid <= 1'b0;
        operand_if.value <= '0;
        quiet_phase      = 1'b0;
        hold_request     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Radix 10 straight from reset: zero, ones, both ends of the range (the most
        // negative value keeps its full magnitude behind the minus sign).
        send_value(32'h0000_0000);
        send_value(32'h0000_0001);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'hFFFF_FFF6);

        // Lowest radix: the longest strings, negatives as raw bit patterns.
        write_radix(RADIX_MIN);
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h0000_0001);

        // Highest radix: letters up to Z.
        write_radix(RADIX_MAX);
        send_value(32'd35);
        send_value(32'd36);
        send_value(32'h7FFF_FFFF);
        send_value(32'hFFFF_FFFF);

        write_radix(6'd16);
        send_value(32'hDEAD_BEEF);
        send_value(32'hA5A5_A5A5);

        // Illegal radices each answer with a single flagged beat.
        write_radix(6'd0);
        send_value(32'd5);
        write_radix(6'd1);
        send_value(32'd7);
        write_radix(6'd37);
        send_value(32'hFFFF_FFFD);
        write_radix(6'd63);
        send_value(32'h0000_0000);

        phase_radix = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd0, 6'd7,
                        6'd63, 6'd8, 6'd1, 6'd10, 6'd37, 6'd0};
        phase_radix[11] = 6'($urandom_range(2, 36));

        for (ph = 0; ph < 12; ph++)
        begin
            r = phase_radix[ph];
            write_radix(r);
            bad         = (r < RADIX_MIN) || (r > RADIX_MAX);
            quiet_phase = (ph == 3) || ($urandom_range(3) == 0);
            count       = bad ? 8 : 52;
            base        = VALUE_W'(r);
            for (n = 0; n < count; n++)
            begin
                // Long binary strings make the best moment to back up the block.
                if (ph == 1 && n == 5)
                    hold_request = 1'b1;
                case ($urandom_range(9))
                    0, 1, 2, 3: v = $urandom;
                    4:          v = $urandom_range(0, 40);
                    5:          v = -$urandom_range(1, 40);
                    6:          v = $urandom >> $urandom_range(0, 31);
                    7:
                    begin
                        case ($urandom_range(4))
                            0:       v = 32'h0000_0000;
                            1:       v = 32'h0000_0001;
                            2:       v = 32'h7FFF_FFFF;
                            3:       v = 32'h8000_0000;
                            default: v = 32'hFFFF_FFFF;
                        endcase
                    end
                    default:
                    begin
                        // Either side of a power of the radix, where the digit
                        // count steps up by one.
                        if (bad)
                            v = $urandom;
                        else
                        begin
                            p = 1;
                            k = $urandom_range(1, 31);
                            repeat (k)
                                if (p <= 32'hFFFF_FFFF / base)
                                    p = p * base;
                            v = p - VALUE_W'($urandom_range(0, 1));
                        end
                    end
                endcase
                send_value(v);
            end
        end

        operand_if.valid <= 1'b0;
        quiet_phase = 1'b0;
        while (sb.owed_chars.size() != 0)
            @(posedge clk);
        // Any stray beat after the last owed one is still caught here.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.bad_chars == 0 && sb.owed_chars.size() == 0)
            $display("[integer_to_ascii_radix_top] OK");
        else
            $display("[integer_to_ascii_radix_top] ERROR");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #60_000_000;
        $display("[integer_to_ascii_radix_top] ERROR");
        $finish;
    end

endmodule
